>>> hdl/sensor_sample_supervisor_assert.svh
// ----------------------------------------------------------------------------
// sensor sample supervisor assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SENSOR_SAMPLE_SUPERVISOR_ASSERT_SVH
`define SENSOR_SAMPLE_SUPERVISOR_ASSERT_SVH

// consequent checked in the same cycle
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// shared types, constants and width helpers of the sensor sample supervisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    // default window depth
    localparam int SSS_AVG_DEPTH = 3;

    // field widths
    localparam int SSS_TEMP_W    = 15;
    localparam int SSS_HUM_W     = 14;
    localparam int SSS_WORD_W    = 16;
    localparam int SSS_CNT_W     = 8;
    localparam int SSS_CFG_IDX_W = 3;

    // sensor range and unit conversion, 0.01 units
    localparam logic signed [14:0] SSS_T_MIN = -15'sd4000;
    localparam logic signed [14:0] SSS_T_MAX = 15'sd12500;
    localparam logic signed [14:0] SSS_H_MIN = 15'sd0;
    localparam logic signed [14:0] SSS_H_MAX = 15'sd10000;
    localparam logic [15:0]        SSS_K_OFS = 16'd27315;
    localparam logic signed [15:0] SSS_F_OFS = 16'sd3200;
    localparam logic [7:0]         SSS_CNT_MAX = 8'hFF;

    // floor(x / 5) = (x * 209716) >> 20, exact for x below 2^18
    localparam logic [17:0] SSS_DIV5_MUL   = 18'd209716;
    localparam int          SSS_DIV5_SHIFT = 20;

    // config reset values
    localparam logic [15:0] SSS_GAIN_ONE     = 16'd16384;
    localparam logic [7:0]  SSS_ERR_LIMIT_RST   = 8'd5;
    localparam logic [7:0]  SSS_STUCK_LIMIT_RST = 8'd100;

    typedef enum logic [SSS_CFG_IDX_W-1:0] {
        REG_TEMP_GAIN   = 3'd0,
        REG_TEMP_OFFSET = 3'd1,
        REG_HUM_GAIN    = 3'd2,
        REG_HUM_OFFSET  = 3'd3,
        REG_ERROR_LIMIT = 3'd4,
        REG_STUCK_LIMIT = 3'd5
    } sss_reg_idx_t;

    typedef struct packed {
        logic [15:0] temp_gain;
        logic [15:0] temp_offset;
        logic [15:0] hum_gain;
        logic [15:0] hum_offset;
        logic [7:0]  error_limit;
        logic [7:0]  stuck_limit;
    } sss_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV_LD,
        ST_DIV,
        ST_CAL,
        ST_CONV,
        ST_FMT,
        ST_FIN
    } sss_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sum_rd;
        logic mul;
        logic div_ld;
        logic div_step;
        logic cal;
        logic conv;
        logic fmt;
        logic fin;
    } sss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } sss_stat_t;

    // quotient width of the averaging divider
    function automatic int sss_quot_w(input int depth);
        return 17 + $clog2(depth);
    endfunction

    function automatic int sss_idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int sss_fill_w(input int depth);
        return $clog2(depth + 1);
    endfunction

    // step counter covers window reads and divider steps
    function automatic int sss_step_w(input int depth);
        int top_val;
        top_val = (depth > sss_quot_w(depth)) ? depth : sss_quot_w(depth);
        return $clog2(top_val + 1);
    endfunction

endpackage

`default_nettype wire

>>> hdl/sss_ifs.sv
// ----------------------------------------------------------------------------
// sss interfaces
// sample, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sss_sample_if import sss_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         sensor_error;
    logic signed [SSS_TEMP_W-1:0] raw_temp;
    logic [SSS_HUM_W-1:0]         raw_hum;

    modport source (output valid, sensor_error, raw_temp, raw_hum, input ready);
    modport sink   (input valid, sensor_error, raw_temp, raw_hum, output ready);
endinterface

interface sss_result_if import sss_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SSS_TEMP_W-1:0] celsius;
    logic [SSS_WORD_W-1:0]        kelvin;
    logic signed [SSS_WORD_W-1:0] fahrenheit;
    logic [SSS_HUM_W-1:0]         humidity;
    logic                         publish;
    logic                         feed_watchdog;
    logic                         save_request;
    logic [SSS_CNT_W-1:0]         temp_repeat_count;
    logic [SSS_CNT_W-1:0]         hum_repeat_count;
    logic [SSS_CNT_W-1:0]         error_run_count;
    logic [SSS_WORD_W-1:0]        good_count;
    logic [SSS_WORD_W-1:0]        feed_count;

    modport source (
        output valid, celsius, kelvin, fahrenheit, humidity, publish, feed_watchdog,
               save_request, temp_repeat_count, hum_repeat_count, error_run_count,
               good_count, feed_count,
        input  ready
    );
    modport sink (
        input  valid, celsius, kelvin, fahrenheit, humidity, publish, feed_watchdog,
               save_request, temp_repeat_count, hum_repeat_count, error_run_count,
               good_count, feed_count,
        output ready
    );
endinterface

interface sss_cfg_if import sss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SSS_CFG_IDX_W-1:0] index;
    logic [SSS_WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/sss_cfg.sv
// ----------------------------------------------------------------------------
// sss_cfg
// calibration and limit register bank behind the configuration channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_cfg import sss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sss_cfg_if.sink   cfg,
    output sss_cfg_t  regs
);

    sss_cfg_t cfg_reg;
    sss_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (sss_reg_idx_t'(cfg.index))
                REG_TEMP_GAIN:   cfg_next.temp_gain   = cfg.data;
                REG_TEMP_OFFSET: cfg_next.temp_offset = cfg.data;
                REG_HUM_GAIN:    cfg_next.hum_gain    = cfg.data;
                REG_HUM_OFFSET:  cfg_next.hum_offset  = cfg.data;
                REG_ERROR_LIMIT: cfg_next.error_limit = cfg.data[7:0];
                REG_STUCK_LIMIT: cfg_next.stuck_limit = cfg.data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_gain   <= SSS_GAIN_ONE;
            cfg_reg.temp_offset <= '0;
            cfg_reg.hum_gain    <= SSS_GAIN_ONE;
            cfg_reg.hum_offset  <= '0;
            cfg_reg.error_limit <= SSS_ERR_LIMIT_RST;
            cfg_reg.stuck_limit <= SSS_STUCK_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sss_ctrl.sv
// ----------------------------------------------------------------------------
// sss_ctrl
// sequencer: window sum, gain multiply, serial divide, calibrate, convert
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_ctrl import sss_pkg::*;
#(
    parameter int AVG_DEPTH = SSS_AVG_DEPTH
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  sss_stat_t                            stat,
    output sss_cmd_t                             cmd,
    output logic [sss_step_w(AVG_DEPTH)-1:0]     step_idx
);

    localparam int T_W    = sss_quot_w(AVG_DEPTH);
    localparam int STEP_W = sss_step_w(AVG_DEPTH);

    sss_state_t        state_reg;
    sss_state_t        state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;

    assign step_idx = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // one window entry read per cycle, then a drain step with no read at the end
                cmd.sum_rd = (cnt_reg < STEP_W'(AVG_DEPTH));
                if (cnt_reg == STEP_W'(AVG_DEPTH))
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_LD;
            end
            ST_DIV_LD:
            begin
                cmd.div_ld = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_W'(T_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_CAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CAL:
            begin
                cmd.cal    = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = ST_FMT;
            end
            ST_FMT:
            begin
                cmd.fmt    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/sss_lane.sv
// ----------------------------------------------------------------------------
// sss_lane
// one channel: sample window, running sum, gain, rounding divide, offset, clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_lane import sss_pkg::*;
#(
    parameter int AVG_DEPTH = SSS_AVG_DEPTH
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  sss_cmd_t                                 cmd,
    input  wire logic [sss_step_w(AVG_DEPTH)-1:0]    step_idx,
    input  wire logic [sss_idx_w(AVG_DEPTH)-1:0]     wr_pos,
    input  wire logic [sss_fill_w(AVG_DEPTH)-1:0]    fill,
    input  wire logic signed [14:0]                  sample_val,
    input  wire logic [15:0]                         gain,
    input  wire logic [15:0]                         offset,
    input  wire logic signed [14:0]                  lo,
    input  wire logic signed [14:0]                  hi,
    output logic signed [14:0]                       value
);

    localparam int SUM_W  = 15 + $clog2(AVG_DEPTH);
    localparam int MAG_W  = SUM_W + 15;
    localparam int T_W    = sss_quot_w(AVG_DEPTH);
    localparam int V_W    = T_W + 2;
    localparam int IDX_W  = sss_idx_w(AVG_DEPTH);
    localparam int FILL_W = sss_fill_w(AVG_DEPTH);
    localparam int STEP_W = sss_step_w(AVG_DEPTH);

    logic signed [14:0]      win_mem [AVG_DEPTH];
    logic signed [14:0]      rd_data_reg;
    logic                    rd_use_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [T_W-1:0]          quo_reg;
    logic [FILL_W-1:0]       rem_reg;
    logic signed [14:0]      value_reg;

    logic [SUM_W-1:0]        acc_abs;
    logic [SUM_W+15:0]       prod;
    logic [MAG_W:0]          half_fill;
    logic [MAG_W:0]          rnd;
    logic [FILL_W:0]         trial;
    logic [FILL_W:0]         diff;
    logic                    ge;
    logic [FILL_W-1:0]       rem_next;
    logic signed [V_W-1:0]   mag_s;
    logic signed [V_W-1:0]   sq;
    logic signed [V_W-1:0]   vsum;
    logic signed [V_W-1:0]   lo_v;
    logic signed [V_W-1:0]   hi_v;
    logic signed [14:0]      value_next;

    assign value = value_reg;

    // window store and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_mem[wr_pos] <= sample_val;
        end
        if (cmd.sum_rd)
        begin
            rd_data_reg <= win_mem[step_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_use_reg <= 1'b0;
        end
        else
        begin
            // only the filled part of the window counts
            rd_use_reg <= cmd.sum_rd && (step_idx < STEP_W'(fill));
        end
    end

    assign acc_abs   = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign prod      = {16'b0, acc_abs} * {{SUM_W{1'b0}}, gain};
    // rounding term fill * 8192 before dropping the 2^14 of the gain
    assign half_fill = {{(MAG_W + 1 - FILL_W - 13){1'b0}}, fill, 13'b0};
    assign rnd       = {1'b0, mag_reg} + half_fill;

    // restoring division by the fill count, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[T_W-1]};
    assign diff     = trial - {1'b0, fill};
    assign ge       = (trial >= {1'b0, fill});
    assign rem_next = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];

    assign mag_s = {2'b00, quo_reg};
    assign sq    = neg_reg ? -mag_s : mag_s;
    assign vsum  = sq + {{(V_W - 16){offset[15]}}, offset};
    assign lo_v  = {{(V_W - 15){lo[14]}}, lo};
    assign hi_v  = {{(V_W - 15){hi[14]}}, hi};

    always_comb
    begin
        if (vsum < lo_v)
        begin
            value_next = lo;
        end
        else if (vsum > hi_v)
        begin
            value_next = hi;
        end
        else
        begin
            value_next = vsum[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (rd_use_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.mul)
        begin
            mag_reg <= prod[MAG_W-1:0];
            neg_reg <= acc_reg[SUM_W-1];
        end
        if (cmd.div_ld)
        begin
            quo_reg <= rnd[MAG_W:14];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[T_W-2:0], ge};
            rem_reg <= rem_next;
        end
        if (cmd.cal)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sss_dp.sv
// ----------------------------------------------------------------------------
// sss_dp
// datapath: health counters, fault latches, two lanes, unit conversion,
// result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_dp import sss_pkg::*;
#(
    parameter int AVG_DEPTH = SSS_AVG_DEPTH
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  sss_cmd_t                              cmd,
    input  wire logic [sss_step_w(AVG_DEPTH)-1:0] step_idx,
    output sss_stat_t                             stat,
    input  sss_cfg_t                              regs,
    input  wire logic                             sensor_error,
    input  wire logic signed [SSS_TEMP_W-1:0]     raw_temp,
    input  wire logic [SSS_HUM_W-1:0]             raw_hum,
    sss_result_if.source                          result
);

    localparam int IDX_W  = sss_idx_w(AVG_DEPTH);
    localparam int FILL_W = sss_fill_w(AVG_DEPTH);

    // health state
    logic [7:0]         erun_reg;
    logic [7:0]         erun_next;
    logic               sfault_reg;
    logic               sfault_next;
    logic               stuck_reg;
    logic               stuck_next;
    logic               saved_reg;
    logic signed [14:0] last_temp_reg;
    logic [13:0]        last_hum_reg;
    logic [7:0]         trep_reg;
    logic [7:0]         trep_next;
    logic [7:0]         hrep_reg;
    logic [7:0]         hrep_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [15:0]        good_reg;
    logic [15:0]        feed_tot_reg;
    logic               publish_reg;
    logic               feed_reg;
    logic               save_reg;
    logic               save_next;
    logic               feed_next;

    // conversion
    logic signed [14:0] temp_val;
    logic signed [14:0] hum_val;
    logic [14:0]        c_abs;
    logic [17:0]        m9_reg;
    logic               f_neg_reg;
    logic [35:0]        prod5;
    logic [14:0]        fq;
    logic signed [15:0] fs;
    logic signed [15:0] f_reg;
    logic [15:0]        kelvin_next;

    // result register
    logic               out_valid_reg;
    logic signed [14:0] o_celsius_reg;
    logic [15:0]        o_kelvin_reg;
    logic signed [15:0] o_fahr_reg;
    logic [13:0]        o_hum_reg;
    logic               o_publish_reg;
    logic               o_feed_reg;
    logic               o_save_reg;
    logic [7:0]         o_trep_reg;
    logic [7:0]         o_hrep_reg;
    logic [7:0]         o_erun_reg;
    logic [15:0]        o_good_reg;
    logic [15:0]        o_feed_cnt_reg;

    // counters and latches as they stand after the incoming word
    always_comb
    begin
        if (sensor_error)
        begin
            erun_next = (erun_reg == SSS_CNT_MAX) ? SSS_CNT_MAX : erun_reg + 1'b1;
        end
        else
        begin
            erun_next = '0;
        end
        sfault_next = sfault_reg || (erun_next > regs.error_limit);

        if (raw_temp == last_temp_reg)
        begin
            trep_next = (trep_reg == SSS_CNT_MAX) ? SSS_CNT_MAX : trep_reg + 1'b1;
        end
        else
        begin
            trep_next = '0;
        end
        if (raw_hum == last_hum_reg)
        begin
            hrep_next = (hrep_reg == SSS_CNT_MAX) ? SSS_CNT_MAX : hrep_reg + 1'b1;
        end
        else
        begin
            hrep_next = '0;
        end
        stuck_next = stuck_reg || (trep_next >= regs.stuck_limit)
                               || (hrep_next >= regs.stuck_limit);

        save_next = (sfault_next || stuck_next) && !saved_reg;
        feed_next = !sfault_next && !stuck_next;

        pos_next  = (pos_reg == IDX_W'(AVG_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        fill_next = (fill_reg < FILL_W'(AVG_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erun_reg      <= '0;
            sfault_reg    <= 1'b0;
            stuck_reg     <= 1'b0;
            saved_reg     <= 1'b0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
            trep_reg      <= '0;
            hrep_reg      <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            good_reg      <= '0;
            feed_tot_reg  <= '0;
            publish_reg   <= 1'b0;
            feed_reg      <= 1'b0;
            save_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            erun_reg      <= erun_next;
            sfault_reg    <= sfault_next;
            stuck_reg     <= stuck_next;
            saved_reg     <= saved_reg || sfault_next || stuck_next;
            last_temp_reg <= raw_temp;
            last_hum_reg  <= raw_hum;
            trep_reg      <= trep_next;
            hrep_reg      <= hrep_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            good_reg      <= good_reg + {15'b0, !sensor_error};
            feed_tot_reg  <= feed_tot_reg + {15'b0, feed_next};
            publish_reg   <= !sensor_error;
            feed_reg      <= feed_next;
            save_reg      <= save_next;
        end
    end

    sss_lane #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_temp_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .step_idx   (step_idx),
        .wr_pos     (pos_reg),
        .fill       (fill_reg),
        .sample_val (raw_temp),
        .gain       (regs.temp_gain),
        .offset     (regs.temp_offset),
        .lo         (SSS_T_MIN),
        .hi         (SSS_T_MAX),
        .value      (temp_val)
    );

    sss_lane #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_hum_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .step_idx   (step_idx),
        .wr_pos     (pos_reg),
        .fill       (fill_reg),
        .sample_val ({1'b0, raw_hum}),
        .gain       (regs.hum_gain),
        .offset     (regs.hum_offset),
        .lo         (SSS_H_MIN),
        .hi         (SSS_H_MAX),
        .value      (hum_val)
    );

    // fahrenheit: round half away of 9|c| / 5 through a reciprocal multiply
    assign c_abs       = temp_val[14] ? (~temp_val + 1'b1) : temp_val;
    assign prod5       = {18'b0, m9_reg} * {18'b0, SSS_DIV5_MUL};
    assign fq          = prod5[SSS_DIV5_SHIFT +: 15];
    assign fs          = {1'b0, fq};
    assign kelvin_next = {temp_val[14], temp_val} + SSS_K_OFS;

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            m9_reg    <= {c_abs, 3'b000} + {3'b000, c_abs} + 18'd2;
            f_neg_reg <= temp_val[14];
        end
        if (cmd.fmt)
        begin
            f_reg <= (f_neg_reg ? -fs : fs) + SSS_F_OFS;
        end
    end

    assign stat.out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            o_celsius_reg  <= temp_val;
            o_kelvin_reg   <= kelvin_next;
            o_fahr_reg     <= f_reg;
            o_hum_reg      <= hum_val[13:0];
            o_publish_reg  <= publish_reg;
            o_feed_reg     <= feed_reg;
            o_save_reg     <= save_reg;
            o_trep_reg     <= trep_reg;
            o_hrep_reg     <= hrep_reg;
            o_erun_reg     <= erun_reg;
            o_good_reg     <= good_reg;
            o_feed_cnt_reg <= feed_tot_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.celsius           = o_celsius_reg;
    assign result.kelvin            = o_kelvin_reg;
    assign result.fahrenheit        = o_fahr_reg;
    assign result.humidity          = o_hum_reg;
    assign result.publish           = o_publish_reg;
    assign result.feed_watchdog     = o_feed_reg;
    assign result.save_request      = o_save_reg;
    assign result.temp_repeat_count = o_trep_reg;
    assign result.hum_repeat_count  = o_hrep_reg;
    assign result.error_run_count   = o_erun_reg;
    assign result.good_count        = o_good_reg;
    assign result.feed_count        = o_feed_cnt_reg;

endmodule

`default_nettype wire

>>> hdl/sensor_sample_supervisor.sv
// ----------------------------------------------------------------------------
// sensor_sample_supervisor
// health supervision and calibration of temperature/humidity sensor samples
//
// Each sample word updates the error-run and stuck-reading counters and their
// fault latches, enters an AVG_DEPTH moving window (fewer entries are averaged
// while it fills), and yields one result word with calibrated, clamped
// celsius and humidity, kelvin, fahrenheit, publish / watchdog / one-shot save
// flags and the counters as they stand after the sample. A new sample is
// taken only when the sequencer is idle, once the previous one has gone
// through window sum, gain multiply, divider load, divide, calibration,
// conversion, formatting and hand-over. The bit-serial divider divides the
// gained window sum by the fill count, one quotient bit a cycle, and its
// quotient width is 17 + clog2(AVG_DEPTH); the window store is read one
// entry a cycle. The result sits in an output register, so the next sample
// is taken while a result still waits; the sequencer only holds in its
// last step if the previous result is still unclaimed. Configuration
// writes are accepted every cycle and should only be issued while no
// sample is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_sample_supervisor import sss_pkg::*;
#(
    parameter int AVG_DEPTH = SSS_AVG_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    sss_sample_if.sink   sample,
    sss_result_if.source result,
    sss_cfg_if.sink      cfg
);

    localparam int STEP_W = sss_step_w(AVG_DEPTH);

    // command and status between sequencer and datapath
    sss_cmd_t          cmd;
    sss_stat_t         stat;
    logic [STEP_W-1:0] step_idx;
    sss_cfg_t          regs;
    logic              in_ready;

    // sample word is taken only when the sequencer is idle
    assign sample.ready = in_ready;

    // calibration gains/offsets and fault limits
    sss_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // sequencer: window sum, multiply, divide, calibrate, convert, hand over
    sss_ctrl #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .step_idx (step_idx)
    );

    // counters, latches, both channel lanes and the result register
    sss_dp #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .step_idx     (step_idx),
        .stat         (stat),
        .regs         (regs),
        .sensor_error (sample.sensor_error),
        .raw_temp     (sample.raw_temp),
        .raw_hum      (sample.raw_hum),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> hdl/sss_port_checker.sv
// ----------------------------------------------------------------------------
// sss_port_checker
// port-level checks on the result channel of the supervisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_sample_supervisor_assert.svh"

module sss_port_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [14:0] celsius,
    input wire logic [15:0]        kelvin,
    input wire logic [13:0]        humidity,
    input wire logic               feed_watchdog,
    input wire logic               save_request
);

    // a word waiting on the result channel stays offered
    `SSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

    // and keeps its celsius and humidity while stalled
    `SSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(celsius) && $stable(humidity), "stalled result word changed")

    // kelvin follows celsius in the same word
    `SSS_ASSERT_NOW(a_kelvin, out_valid,
        kelvin == 16'($signed(celsius) + 16'sd27315), "kelvin does not match celsius")

    // a save request means a fault latch is set, so no watchdog feed
    `SSS_ASSERT_NOW(a_save_feed, out_valid && save_request, !feed_watchdog,
        "save request with watchdog feed")

endmodule

bind sensor_sample_supervisor sss_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .celsius       (result.celsius),
    .kelvin        (result.kelvin),
    .humidity      (result.humidity),
    .feed_watchdog (result.feed_watchdog),
    .save_request  (result.save_request)
);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor sample supervisor testbench
// drives sample words and register writes through the valid/ready channels,
// predicts every result word from its own model of the supervisor (fault
// counters and latches, moving window, calibration, unit conversion) and
// checks each result field by field in order of arrival
// ----------------------------------------------------------------------------

module testbench import sss_pkg::*; ();

    localparam int WIN_DEPTH   = SSS_AVG_DEPTH;
    localparam int STALL_LIMIT = 2000;

    // register indexes past the last register, which the block must ignore
    localparam logic [SSS_CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [SSS_CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // one result word as the block presents it
    typedef struct packed {
        logic signed [SSS_TEMP_W-1:0] celsius;
        logic [SSS_WORD_W-1:0]        kelvin;
        logic signed [SSS_WORD_W-1:0] fahrenheit;
        logic [SSS_HUM_W-1:0]         humidity;
        logic                         publish;
        logic                         feed_watchdog;
        logic                         save_request;
        logic [SSS_CNT_W-1:0]         temp_repeat_count;
        logic [SSS_CNT_W-1:0]         hum_repeat_count;
        logic [SSS_CNT_W-1:0]         error_run_count;
        logic [SSS_WORD_W-1:0]        good_count;
        logic [SSS_WORD_W-1:0]        feed_count;
    } reading_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of settings and supervision state, queue of
    // predicted result words
    // ------------------------------------------------------------------------
    class reading_scoreboard;
        bit [15:0]        temp_gain;
        bit signed [15:0] temp_offset;
        bit [15:0]        hum_gain;
        bit signed [15:0] hum_offset;
        bit [7:0]         error_limit;
        bit [7:0]         stuck_limit;

        bit [7:0]         error_run;
        bit [7:0]         temp_repeats;
        bit [7:0]         hum_repeats;
        bit               sensor_fault;
        bit               stuck_fault;
        bit               saved_flag;
        bit signed [14:0] last_temp;
        bit [13:0]        last_hum;
        longint           temp_window[WIN_DEPTH];
        longint           hum_window[WIN_DEPTH];
        int               window_pos;
        int               window_fill;
        bit [15:0]        good_total;
        bit [15:0]        feed_total;

        reading_t         expected_readings[$];
        int               mismatches;

        function new();
            temp_gain    = SSS_GAIN_ONE;
            hum_gain     = SSS_GAIN_ONE;
            temp_offset  = 0;
            hum_offset   = 0;
            error_limit  = SSS_ERR_LIMIT_RST;
            stuck_limit  = SSS_STUCK_LIMIT_RST;
            error_run    = 0;
            temp_repeats = 0;
            hum_repeats  = 0;
            sensor_fault = 0;
            stuck_fault  = 0;
            saved_flag   = 0;
            last_temp    = 0;
            last_hum     = 0;
            window_pos   = 0;
            window_fill  = 0;
            good_total   = 0;
            feed_total   = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void set_reg(logic [SSS_CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_TEMP_GAIN:   temp_gain   = value;
                REG_TEMP_OFFSET: temp_offset = value;
                REG_HUM_GAIN:    hum_gain    = value;
                REG_HUM_OFFSET:  hum_offset  = value;
                REG_ERROR_LIMIT: error_limit = value[7:0];
                REG_STUCK_LIMIT: stuck_limit = value[7:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] bump(bit [7:0] n);
            return (n == SSS_CNT_MAX) ? n : n + 8'd1;
        endfunction

        // nearest, ties away from zero
        function longint round_half_away(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint calibrated(longint sum, int fill, longint gain, longint ofs,
                                    longint lo, longint hi);
            longint v;
            v = round_half_away(sum * gain, longint'(fill) * longint'(SSS_GAIN_ONE)) + ofs;
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void note_sample(logic err, logic signed [14:0] rt, logic [13:0] rh);
            reading_t r;
            longint   tsum;
            longint   hsum;
            longint   c;
            longint   h;
            longint   k;
            longint   f;
            tsum = 0;
            hsum = 0;

            error_run = err ? bump(error_run) : 8'd0;
            if (error_run > error_limit)
                sensor_fault = 1'b1;

            if (rh == last_hum)
                hum_repeats = bump(hum_repeats);
            else
            begin
                hum_repeats = 0;
                last_hum    = rh;
            end
            if (rt == last_temp)
                temp_repeats = bump(temp_repeats);
            else
            begin
                temp_repeats = 0;
                last_temp    = rt;
            end

            if (window_pos >= WIN_DEPTH)
                window_pos = 0;
            temp_window[window_pos] = rt;
            hum_window[window_pos]  = rh;
            window_pos++;
            if (window_fill < WIN_DEPTH)
                window_fill++;
            for (int i = 0; i < window_fill; i++)
            begin
                tsum += temp_window[i];
                hsum += hum_window[i];
            end

            c = calibrated(tsum, window_fill, temp_gain, temp_offset, SSS_T_MIN, SSS_T_MAX);
            h = calibrated(hsum, window_fill, hum_gain, hum_offset, SSS_H_MIN, SSS_H_MAX);
            k = c + longint'(SSS_K_OFS);
            f = round_half_away(c * 9, 5) + SSS_F_OFS;

            if (!err)
                good_total++;
            if (temp_repeats >= stuck_limit || hum_repeats >= stuck_limit)
                stuck_fault = 1'b1;

            r.save_request = 1'b0;
            if ((sensor_fault || stuck_fault) && !saved_flag)
            begin
                r.save_request = 1'b1;
                saved_flag     = 1'b1;
            end
            r.feed_watchdog = !sensor_fault && !stuck_fault;
            if (r.feed_watchdog)
                feed_total++;

            r.celsius           = c[14:0];
            r.kelvin            = k[15:0];
            r.fahrenheit        = f[15:0];
            r.humidity          = h[13:0];
            r.publish           = !err;
            r.temp_repeat_count = temp_repeats;
            r.hum_repeat_count  = hum_repeats;
            r.error_run_count   = error_run;
            r.good_count        = good_total;
            r.feed_count        = feed_total;
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: result word with no sample pending, celsius %0d",
                         $time, got.celsius);
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("celsius", $signed(want.celsius), $signed(got.celsius));
            compare_field("kelvin", want.kelvin, got.kelvin);
            compare_field("fahrenheit", $signed(want.fahrenheit), $signed(got.fahrenheit));
            compare_field("humidity", want.humidity, got.humidity);
            compare_field("publish", want.publish, got.publish);
            compare_field("feed_watchdog", want.feed_watchdog, got.feed_watchdog);
            compare_field("save_request", want.save_request, got.save_request);
            compare_field("temp_repeat_count", want.temp_repeat_count, got.temp_repeat_count);
            compare_field("hum_repeat_count", want.hum_repeat_count, got.hum_repeat_count);
            compare_field("error_run_count", want.error_run_count, got.error_run_count);
            compare_field("good_count", want.good_count, got.good_count);
            compare_field("feed_count", want.feed_count, got.feed_count);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // random idling on the sample side and stalls on the result side
    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    reading_scoreboard sb;

    sss_sample_if sample_bus ();
    sss_result_if result_bus ();
    sss_cfg_if    cfg_bus ();

    sensor_sample_supervisor u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: ready drops for bursts of random length when stalls are on
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left       <= stall_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (receiver_idle && $urandom_range(0, 4) == 0)
        begin
            stall_left       <= $urandom_range(0, 5);
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= 1'b1;
    end

    // every result word taken at a rising edge goes to the scoreboard
    always @(posedge clk)
    begin : result_monitor
        reading_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.celsius           = result_bus.celsius;
            got.kelvin            = result_bus.kelvin;
            got.fahrenheit        = result_bus.fahrenheit;
            got.humidity          = result_bus.humidity;
            got.publish           = result_bus.publish;
            got.feed_watchdog     = result_bus.feed_watchdog;
            got.save_request      = result_bus.save_request;
            got.temp_repeat_count = result_bus.temp_repeat_count;
            got.hum_repeat_count  = result_bus.hum_repeat_count;
            got.error_run_count   = result_bus.error_run_count;
            got.good_count        = result_bus.good_count;
            got.feed_count        = result_bus.feed_count;
            sb.check_reading(got);
        end
    end

    // watchdog: a long spell with no word moving on any channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_bus.valid && sample_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL sensor_sample_supervisor");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // inputs change on the falling edge, the handshake is seen on the rising one
    task automatic send_sample(input logic err, input int t, input int h);
        int gap;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            sample_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_bus.valid        <= 1'b1;
        sample_bus.sensor_error <= err;
        sample_bus.raw_temp     <= t[14:0];
        sample_bus.raw_hum      <= h[13:0];
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        sb.note_sample(err, t[14:0], h[13:0]);
    endtask

    task automatic write_reg(input logic [SSS_CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic apply_settings(input int tg, input int to, input int hg, input int ho,
                                  input int el, input int sl);
        write_reg(REG_TEMP_GAIN, tg[15:0]);
        write_reg(REG_TEMP_OFFSET, to[15:0]);
        write_reg(REG_HUM_GAIN, hg[15:0]);
        write_reg(REG_HUM_OFFSET, ho[15:0]);
        write_reg(REG_ERROR_LIMIT, el[15:0]);
        write_reg(REG_STUCK_LIMIT, sl[15:0]);
    endtask

    // every result in, so no sample is in flight and registers may change
    task automatic wait_drained();
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int rand_temp();
        return int'($urandom_range(0, 17500)) - 4500;
    endfunction

    function automatic int rand_hum();
        return int'($urandom_range(0, 10000));
    endfunction

    function automatic int small_offset();
        return int'($urandom_range(0, 4000)) - 2000;
    endfunction

    // mix of plain readings, runs of repeated readings, error runs and
    // readings at the edges of the sensor range
    task automatic random_run(input int n_items, input int err_burst_max,
                              input int rep_burst_max);
        int sent;
        int kind;
        int len;
        int mode;
        int t;
        int h;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            t    = rand_temp();
            h    = rand_hum();
            if (kind <= 4)
            begin
                send_sample($urandom_range(0, 7) == 0, t, h);
                sent++;
            end
            else if (kind <= 6)
            begin
                // 0: both channels held, 1: temperature only, 2: humidity only
                mode = $urandom_range(0, 2);
                len  = $urandom_range(2, rep_burst_max);
                for (int i = 0; i < len; i++)
                    send_sample($urandom_range(0, 7) == 0,
                                (mode != 2) ? t : rand_temp(),
                                (mode != 1) ? h : rand_hum());
                sent += len;
            end
            else if (kind == 7)
            begin
                len = $urandom_range(1, err_burst_max);
                for (int i = 0; i < len; i++)
                    send_sample(1'b1, rand_temp(), rand_hum());
                sent += len;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: t = -4500;
                    1: t = -4000;
                    2: t = -1;
                    3: t = 0;
                    4: t = 12500;
                    default: t = 13000;
                endcase
                case ($urandom_range(0, 3))
                    0: h = 0;
                    1: h = 1;
                    2: h = 9999;
                    default: h = 10000;
                endcase
                send_sample($urandom_range(0, 3) == 0, t, h);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        sample_bus.valid        = 1'b0;
        sample_bus.sensor_error = 1'b0;
        sample_bus.raw_temp     = '0;
        sample_bus.raw_hum      = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = '0;
        cfg_bus.data            = '0;
        result_bus.ready        = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset settings
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;

        // first reading of zero matches the cleared last values and counts as a repeat
        send_sample(1'b0, 0, 0);
        send_sample(1'b0, 0, 0);
        // range extremes, the first of them while the window is still filling
        send_sample(1'b0, -4500, 10000);
        send_sample(1'b0, 13000, 0);
        send_sample(1'b0, 13000, 0);
        // erroneous readings still move the window and the repeat counters
        send_sample(1'b1, 13000, 0);
        send_sample(1'b1, -4500, 10000);
        send_sample(1'b1, -1, 1);
        send_sample(1'b1, 12500, 9999);
        // fifth error in a row sits at the limit without passing it
        send_sample(1'b1, -4000, 5000);
        send_sample(1'b0, -4000, 5000);
        send_sample(1'b0, 8191, 8191);
        send_sample(1'b0, -8192, 8192);
        send_sample(1'b0, 2500, 4500);
        send_sample(1'b0, -4500, 0);
        send_sample(1'b0, 13000, 10000);
        send_sample(1'b0, 1, 1);
        wait_drained();

        // near-unity calibration, fault limits out of reach
        apply_settings($urandom_range(12000, 22000), small_offset(),
                       $urandom_range(12000, 22000), small_offset(), 255, 255);
        write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
        random_run(100, 20, 40);
        // long error run saturates the counter yet never exceeds a limit of 255
        for (int i = 0; i < 300; i++)
            send_sample(1'b1, rand_temp(), rand_hum());
        wait_drained();

        // calibration extremes, both ways round
        apply_settings(0, -32768, 65535, 32767, 255, 255);
        random_run(100, 20, 40);
        wait_drained();
        apply_settings(65535, 32767, 0, -32768, 40, 200);
        random_run(100, 20, 40);
        wait_drained();

        // random settings, idling switched per phase
        for (int p = 0; p < 4; p++)
        begin
            sender_idle   = $urandom_range(0, 2) != 0;
            receiver_idle = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 1) == 0)
                apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(40, 255), $urandom_range(100, 255));
            else
                apply_settings($urandom_range(12000, 22000), small_offset(),
                               $urandom_range(12000, 22000), small_offset(),
                               $urandom_range(40, 255), $urandom_range(100, 255));
            random_run(100, 20, 40);
            wait_drained();
        end

        // last part without idling: low limits so the fault latches trip and
        // the one-shot save fires
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        wait_drained();
        write_reg(REG_ERROR_LIMIT, 16'($urandom_range(0, 6)));
        write_reg(REG_STUCK_LIMIT, 16'($urandom_range(0, 8)));
        random_run(200, 10, 12);
        wait_drained();
        // zero limits: the stuck compare holds from here on, the error compare on any error
        write_reg(REG_STUCK_LIMIT, 16'd0);
        write_reg(REG_ERROR_LIMIT, 16'd0);
        // one reading held long enough for both repeat counters to saturate
        for (int i = 0; i < 300; i++)
            send_sample(1'b0, 2150, 4321);
        random_run(60, 10, 12);

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS sensor_sample_supervisor");
        else
            $display("FAIL sensor_sample_supervisor");
        $finish;
    end

endmodule
